/* hdl/cngl_pkg.sv */
`default_nettype none

package cngl_pkg;

    // default grid sizes
    localparam int MAX_CN_DEF     = 15;
    localparam int GRID_STEPS_DEF = 100;
    localparam int STEP_DIV       = 100;

    // fixed point values: signed Q32.16 held within +-(2^47 - 1)
    typedef logic signed [47:0] value_t;
    typedef logic signed [48:0] wide_t;

    localparam value_t LIM    = 48'sh7FFF_FFFF_FFFF;
    localparam wide_t  LIM_W  = 49'sh0_7FFF_FFFF_FFFF;
    localparam value_t FORBID = 48'sd65470464;  // 999.0

    // input actions
    typedef enum logic [1:0] {
        ACT_WR_FIRST  = 2'd0,
        ACT_WR_SECOND = 2'd1,
        ACT_EVAL      = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CN_MAX      = 3'd0,
        CFG_PSCN_MAX    = 3'd1,
        CFG_ALLELE_VAR  = 3'd2,
        CFG_TOTAL_VAR   = 3'd3,
        CFG_DEPTH_SCALE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [31:0] prior_value;
        logic [6:0]  normal_step;
        logic [31:0] total_cn_measure;
        logic [31:0] total_cn_weight;
        logic [16:0] allele_fraction;
        logic [31:0] allele_weight;
    } in_item_t;

    typedef struct packed {
        logic [47:0] neg_log_lik;
        logic [3:0]  best_column;
        logic [3:0]  best_minor;
    } out_item_t;

    // arithmetic unit operations
    typedef enum logic {
        OP_DIV   = 1'b0,
        OP_GCOST = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
        value_t    x;
        value_t    mean;
        value_t    d;
    } arith_req_t;

    typedef struct packed {
        logic   done;
        value_t value;
    } arith_rsp_t;

    // prior table write request
    typedef struct packed {
        logic        en;
        logic        second;
        logic [7:0]  addr;
        logic [31:0] data;
    } mem_wr_t;

    // normal fraction table, round(step * 65536 / 100) half up
    typedef logic [16:0] np_table_t [128];

    function automatic np_table_t make_np_table();
        np_table_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 17'((i * 65536 + STEP_DIV / 2) / STEP_DIV);
        end
        return t;
    endfunction

    localparam np_table_t NP_TABLE = make_np_table();

    // saturate into +-(2^47 - 1)
    function automatic value_t sat(input wide_t x);
        value_t r;
        if (x > LIM_W) begin
            r = LIM;
        end else if (x < -LIM_W) begin
            r = -LIM;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    // magnitude as unsigned
    function automatic logic [47:0] mag(input value_t x);
        logic [47:0] r;
        r = x[47] ? 48'(-x) : 48'(x);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/copy_number_grid_likelihood.sv */
// Copy-number grid likelihood engine.
// Input channel (in_valid / in_ready / in_item) takes one request at a time.
// Prior write requests (action 0 and 1) store one entry in a 256-entry table;
// they and action 3 return nothing. An evaluate request
// (action 2) returns one result on the output channel (out_valid / out_ready /
// out_item): least cost, its column and the minor allele offset.
// Configuration registers are written through cfg_valid / cfg_index / cfg_data;
// cfg_ready is always high.
// One shared arithmetic unit does every division and squared cost, in
// bit-serial shift-add multiply and restoring divide loops.
// in_ready is high only between evaluations; a finished result sits in the
// output register, so the next request is taken while it waits. If the
// receiver still stalls when the next result is ready, the engine holds it.
// Reset clears control state and loads the register defaults; prior tables
// are not cleared and must be written before use.
`default_nettype none

module copy_number_grid_likelihood #(
    parameter int MAX_CN     = cngl_pkg::MAX_CN_DEF,
    parameter int GRID_STEPS = cngl_pkg::GRID_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cngl_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cngl_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cngl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SETUP = 8'b00000010,
        S_PAIR  = 8'b00000100,
        S_RD    = 8'b00001000,
        S_PSDIV = 8'b00010000,
        S_AG    = 8'b00100000,
        S_TOT   = 8'b01000000,
        S_FIN   = 8'b10000000
    } state_t;

    state_t      state_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [3:0]  cn_max_reg;
    logic [3:0]  pscn_max_reg;
    logic [31:0] allele_var_reg;
    logic [31:0] total_var_reg;
    logic [31:0] depth_scale_reg;
    in_item_t    item_reg;
    logic [2:0]  setup_step_reg;
    value_t      cn_reg;
    value_t      t_reg;
    value_t      dt_reg;
    value_t      db_reg;
    logic [3:0]  r1_reg;
    logic [3:0]  r2_reg;
    logic [3:0]  a_reg;
    logic [3:0]  b_reg;
    value_t      lint_reg;
    value_t      lmin_reg;
    logic [3:0]  mcol_reg;
    logic        got_reg;
    value_t      psq_reg;
    value_t      pr_reg;
    value_t      best_reg;
    logic [3:0]  best_col_reg;
    logic        have_reg;
    logic [3:0]  minor0_reg [16];

    logic [3:0]  c_eff;
    logic [6:0]  step_eff;
    logic [16:0] np;
    logic [16:0] tp;
    logic [3:0]  r1lo, r1hi, r2lo, r2hi;
    logic        sub_empty;
    logic [5:0]  sr_full, sc_full;
    logic        cn_forbid, ps_forbid;
    logic [20:0] r2_tp, b_tp;
    value_t      cnv, ps;
    value_t      pr_sum;
    value_t      v_cost;
    value_t      tot;
    logic        sub_last;
    logic        fin_load;
    arith_req_t  arith_req;
    arith_rsp_t  arith_rsp;
    mem_wr_t     mem_wr;
    logic [31:0] rd_first, rd_second;

    // effective grid limits
    always_comb
    begin
        if (cn_max_reg > 4'(MAX_CN))
        begin
            c_eff = 4'(MAX_CN);
        end
        else if (cn_max_reg < 4'd3)
        begin
            c_eff = 4'd3;
        end
        else
        begin
            c_eff = cn_max_reg;
        end
        step_eff = (item_reg.normal_step >= 7'(GRID_STEPS)) ? 7'(GRID_STEPS - 1)
                                                             : item_reg.normal_step;
    end

    // normal and tumor fractions
    assign np = NP_TABLE[step_eff];
    assign tp = 17'h10000 - np;

    // allele ranges of the current pair
    assign r1lo      = (r1_reg > pscn_max_reg) ? r1_reg - pscn_max_reg : 4'd0;
    assign r1hi      = (r1_reg > pscn_max_reg) ? pscn_max_reg : r1_reg;
    assign r2lo      = (r2_reg > pscn_max_reg) ? r2_reg - pscn_max_reg : 4'd0;
    assign r2hi      = (r2_reg > pscn_max_reg) ? pscn_max_reg : r2_reg;
    assign sub_empty = (r1lo > r1hi) || (r2lo > r2hi);
    assign sub_last  = (a_reg == r1hi) && (b_reg == r2hi);

    // second prior is read at the complementary index
    assign sr_full = 6'(c_eff) - 6'(r1hi) + 6'(a_reg) - 6'(r1lo);
    assign sc_full = 6'(c_eff) - 6'(r2hi) + 6'(b_reg) - 6'(r2lo);

    // copy and allele grid means
    assign cn_forbid = ((r1_reg <= 4'd1) && (r2_reg >= 4'd3))
                    || ((r1_reg >= 4'd3) && (r2_reg <= 4'd1));
    assign ps_forbid = ((a_reg == 4'd0) && (b_reg >= 4'd2))
                    || ((a_reg >= 4'd2) && (b_reg == 4'd0));
    assign r2_tp = 21'(r2_reg) * 21'(tp);
    assign b_tp  = 21'(b_reg) * 21'(tp);
    assign cnv   = cn_forbid ? FORBID : value_t'(48'(np) + 48'(np) + 48'(r2_tp));
    assign ps    = ps_forbid ? FORBID : value_t'(48'(np) + 48'(b_tp));

    // prior sum, allele cost and pair total
    assign pr_sum = value_t'(signed'(rd_first)) + value_t'(signed'(rd_second));
    assign v_cost = sat(wide_t'(arith_rsp.value) + wide_t'(pr_reg));
    assign tot    = sat(wide_t'(lint_reg) + wide_t'(lmin_reg));

    // result register loads when the final step finds it free
    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // arithmetic request select
    always_comb
    begin
        arith_req.start = 1'b0;
        arith_req.op    = OP_DIV;
        arith_req.x     = '0;
        arith_req.mean  = '0;
        arith_req.d     = '0;
        unique case (state_reg)
            S_SETUP:
            begin
                arith_req.start = !busy_reg;
                unique case (setup_step_reg)
                    3'd0:
                    begin
                        arith_req.x = value_t'(signed'(item_reg.total_cn_measure));
                        arith_req.d = value_t'(48'(depth_scale_reg));
                    end
                    3'd1:
                    begin
                        arith_req.x = value_t'(48'(total_var_reg));
                        arith_req.d = value_t'(48'(depth_scale_reg));
                    end
                    3'd2:
                    begin
                        arith_req.x = t_reg;
                        arith_req.d = value_t'(48'(depth_scale_reg));
                    end
                    3'd3:
                    begin
                        arith_req.x = t_reg;
                        arith_req.d = value_t'(48'(item_reg.total_cn_weight));
                    end
                    default:
                    begin
                        arith_req.x = value_t'(48'(allele_var_reg));
                        arith_req.d = value_t'(48'(item_reg.allele_weight));
                    end
                endcase
            end
            S_PAIR:
            begin
                arith_req.start = !busy_reg;
                arith_req.op    = OP_GCOST;
                arith_req.x     = cnv;
                arith_req.mean  = cn_reg;
                arith_req.d     = dt_reg;
            end
            S_PSDIV:
            begin
                arith_req.start = !busy_reg;
                arith_req.x     = ps;
                arith_req.d     = cn_reg;
            end
            S_AG:
            begin
                arith_req.start = !busy_reg;
                arith_req.op    = OP_GCOST;
                arith_req.x     = psq_reg;
                arith_req.mean  = value_t'(48'(item_reg.allele_fraction));
                arith_req.d     = db_reg;
            end
            default:
            begin
                arith_req.start = 1'b0;
            end
        endcase
    end

    // prior write requests
    always_comb
    begin
        mem_wr.en     = (state_reg == S_IDLE) && in_valid
                     && ((in_item.action == ACT_WR_FIRST) || (in_item.action == ACT_WR_SECOND));
        mem_wr.second = (in_item.action == ACT_WR_SECOND);
        mem_wr.addr   = {in_item.row_index, in_item.col_index};
        mem_wr.data   = in_item.prior_value;
    end

    cngl_arith u_arith (
        .clk (clk),
        .rst_n (rst_n),
        .req (arith_req),
        .rsp (arith_rsp)
    );

    cngl_mem u_mem (
        .clk            (clk),
        .wr             (mem_wr),
        .rd_addr_first  ({a_reg, b_reg}),
        .rd_addr_second ({sr_full[3:0], sc_full[3:0]}),
        .rd_data_first  (rd_first),
        .rd_data_second (rd_second)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            cn_max_reg      <= 4'd7;
            pscn_max_reg    <= 4'd3;
            allele_var_reg  <= 32'h0001_0000;
            total_var_reg   <= 32'h0001_0000;
            depth_scale_reg <= 32'h0001_0000;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CN_MAX:      cn_max_reg      <= cfg_data[3:0];
                    CFG_PSCN_MAX:    pscn_max_reg    <= cfg_data[3:0];
                    CFG_ALLELE_VAR:  allele_var_reg  <= cfg_data;
                    CFG_TOTAL_VAR:   total_var_reg   <= cfg_data;
                    CFG_DEPTH_SCALE: depth_scale_reg <= cfg_data;
                    default:         ;
                endcase
            end

            // outstanding arithmetic request
            if (arith_req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (arith_rsp.done)
            begin
                busy_reg <= 1'b0;
            end

            // output valid: load a new result or drop an accepted one
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (in_item.action == ACT_EVAL))
                    begin
                        item_reg       <= in_item;
                        setup_step_reg <= 3'd0;
                        state_reg      <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    if (arith_rsp.done)
                    begin
                        case (setup_step_reg)
                            3'd0:    cn_reg <= arith_rsp.value;
                            3'd1:    t_reg  <= arith_rsp.value;
                            3'd2:    t_reg  <= arith_rsp.value;
                            3'd3:    dt_reg <= arith_rsp.value;
                            default: db_reg <= arith_rsp.value;
                        endcase
                        if (setup_step_reg == 3'd4)
                        begin
                            r1_reg    <= 4'd0;
                            r2_reg    <= 4'd0;
                            have_reg  <= 1'b0;
                            state_reg <= S_PAIR;
                        end
                        else
                        begin
                            setup_step_reg <= setup_step_reg + 3'd1;
                        end
                    end
                end
                S_PAIR:
                begin
                    if (arith_rsp.done)
                    begin
                        lint_reg  <= arith_rsp.value;
                        a_reg     <= r1lo;
                        b_reg     <= r2lo;
                        got_reg   <= 1'b0;
                        lmin_reg  <= '0;
                        mcol_reg  <= 4'd0;
                        state_reg <= sub_empty ? S_TOT : S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_PSDIV;
                end
                S_PSDIV:
                begin
                    if (arith_rsp.done)
                    begin
                        psq_reg   <= arith_rsp.value;
                        pr_reg    <= pr_sum;
                        state_reg <= S_AG;
                    end
                end
                S_AG:
                begin
                    if (arith_rsp.done)
                    begin
                        if (!got_reg || (v_cost < lmin_reg))
                        begin
                            lmin_reg <= v_cost;
                            mcol_reg <= b_reg - r2lo;
                            got_reg  <= 1'b1;
                        end
                        if (sub_last)
                        begin
                            state_reg <= S_TOT;
                        end
                        else
                        begin
                            if (a_reg == r1hi)
                            begin
                                a_reg <= r1lo;
                                b_reg <= b_reg + 4'd1;
                            end
                            else
                            begin
                                a_reg <= a_reg + 4'd1;
                            end
                            state_reg <= S_RD;
                        end
                    end
                end
                S_TOT:
                begin
                    if (r1_reg == 4'd0)
                    begin
                        minor0_reg[r2_reg] <= mcol_reg;
                    end
                    if (!have_reg || (tot < best_reg))
                    begin
                        best_reg     <= tot;
                        best_col_reg <= r2_reg;
                        have_reg     <= 1'b1;
                    end
                    if (r1_reg == c_eff)
                    begin
                        r1_reg <= 4'd0;
                        if (r2_reg == c_eff)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            r2_reg    <= r2_reg + 4'd1;
                            state_reg <= S_PAIR;
                        end
                    end
                    else
                    begin
                        r1_reg    <= r1_reg + 4'd1;
                        state_reg <= S_PAIR;
                    end
                end
                S_FIN:
                begin
                    if (fin_load)
                    begin
                        out_item_reg.neg_log_lik <= best_reg;
                        out_item_reg.best_column <= best_col_reg;
                        out_item_reg.best_minor  <= minor0_reg[best_col_reg];
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a result comes back only for an outstanding request
    assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> busy_reg)
        else $error("arithmetic result without request");

    // a new result is loaded only at the end of an evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final step");

    // table writes only while no evaluation is running
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> in_ready)
        else $error("table write during evaluation");

    // pair indexes stay inside the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR) |-> ((r1_reg <= c_eff) && (r2_reg <= c_eff)))
        else $error("pair index out of grid");

    // allele indexes stay inside the sub-block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AG) |-> ((a_reg >= r1lo) && (a_reg <= r1hi)
                              && (b_reg >= r2lo) && (b_reg <= r2hi)))
        else $error("allele index out of sub-block");

endmodule

`default_nettype wire

/* hdl/cngl_mem.sv */
`default_nettype none

module cngl_mem (
    input  logic               clk,
    input  cngl_pkg::mem_wr_t  wr,
    input  logic [7:0]         rd_addr_first,
    input  logic [7:0]         rd_addr_second,
    output logic [31:0]        rd_data_first,
    output logic [31:0]        rd_data_second
);
    import cngl_pkg::*;

    logic [31:0] first_mem  [256];
    logic [31:0] second_mem [256];

    // first prior table
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.second)
        begin
            first_mem[wr.addr] <= wr.data;
        end
        rd_data_first <= first_mem[rd_addr_first];
    end

    // second prior table
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.second)
        begin
            second_mem[wr.addr] <= wr.data;
        end
        rd_data_second <= second_mem[rd_addr_second];
    end

endmodule

`default_nettype wire

/* hdl/cngl_arith.sv */
`default_nettype none

module cngl_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cngl_pkg::arith_req_t req,
    output cngl_pkg::arith_rsp_t rsp
);
    import cngl_pkg::*;

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_MUL  = 6'b000010,
        A_PREP = 6'b000100,
        A_DIV  = 6'b001000,
        A_FIX  = 6'b010000,
        A_DONE = 6'b100000
    } astate_t;

    astate_t     state_reg;
    logic [5:0]  cnt_reg;
    logic [95:0] mcand_reg;
    logic [47:0] mplier_reg;
    logic [95:0] acc_reg;
    value_t      dvd_reg;
    value_t      dvs_reg;
    logic        halve_reg;
    logic        neg_reg;
    logic [47:0] ub_reg;
    logic [47:0] rem_reg;
    logic [63:0] quo_reg;
    value_t      res_reg;

    logic [95:0] acc_next;
    logic [48:0] rem_sh;
    logic        rem_ge;
    logic [47:0] rem_next;
    logic [63:0] quo_next;
    value_t      diff;
    logic [47:0] diff_mag;
    logic [47:0] q_mag;
    value_t      q_signed;
    value_t      zero_q;

    // shift-add multiplier step
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // restoring divider step
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_ge   = rem_sh >= {1'b0, ub_reg};
    assign rem_next = rem_ge ? 48'(rem_sh - {1'b0, ub_reg}) : rem_sh[47:0];
    assign quo_next = {quo_reg[62:0], rem_ge};

    // difference for the squared cost
    assign diff     = sat(wide_t'(req.x) - wide_t'(req.mean));
    assign diff_mag = mag(diff);

    // quotient clamp and sign
    assign q_mag    = (quo_reg > 64'(LIM)) ? 48'(LIM) : quo_reg[47:0];
    assign q_signed = neg_reg ? -value_t'(q_mag) : value_t'(q_mag);
    assign zero_q   = dvd_reg[47] ? -LIM : LIM;

    // halve toward zero for the cost
    function automatic value_t post(input value_t q, input logic halve);
        value_t r;
        r = halve ? ((q + value_t'(q[47])) >>> 1) : q;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        if (req.op == OP_GCOST)
                        begin
                            mcand_reg  <= 96'(diff_mag);
                            mplier_reg <= diff_mag;
                            acc_reg    <= '0;
                            cnt_reg    <= '0;
                            dvs_reg    <= req.d;
                            halve_reg  <= 1'b1;
                            state_reg  <= A_MUL;
                        end
                        else
                        begin
                            dvd_reg   <= req.x;
                            dvs_reg   <= req.d;
                            halve_reg <= 1'b0;
                            state_reg <= A_PREP;
                        end
                    end
                end
                A_MUL:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= {mcand_reg[94:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[47:1]};
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47)
                    begin
                        dvd_reg   <= (acc_next[95:63] != '0) ? LIM : value_t'(acc_next[63:16]);
                        state_reg <= A_PREP;
                    end
                end
                A_PREP:
                begin
                    if (dvs_reg == '0)
                    begin
                        res_reg   <= post(zero_q, halve_reg);
                        state_reg <= A_DONE;
                    end
                    else
                    begin
                        neg_reg   <= dvd_reg[47] ^ dvs_reg[47];
                        ub_reg    <= mag(dvs_reg);
                        rem_reg   <= '0;
                        quo_reg   <= {mag(dvd_reg), 16'b0};
                        cnt_reg   <= '0;
                        state_reg <= A_DIV;
                    end
                end
                A_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX:
                begin
                    res_reg   <= post(q_signed, halve_reg);
                    state_reg <= A_DONE;
                end
                A_DONE:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = (state_reg == A_DONE);
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

/* sim/tb_copy_number_grid_likelihood.sv */
`timescale 1ns / 1ps

module tb_copy_number_grid_likelihood;
    import cngl_pkg::*;

    localparam longint SAT_MAX   = 64'sh7FFF_FFFF_FFFF;
    localparam longint ONE_FX    = 65536;
    localparam longint FORBID_FX = 999 * 65536;
    localparam int     CYCLE_CAP = 20_000_000;

    // directed stimulus row: settings plus one request
    typedef struct {
        logic [3:0]  cn_max;
        logic [3:0]  ps_max;
        logic [31:0] a_var;
        logic [31:0] t_var;
        logic [31:0] d_scale;
        in_item_t    req;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the block's settings and prior tables
    logic [3:0]  m_cn_max;
    logic [3:0]  m_ps_max;
    logic [31:0] m_allele_var;
    logic [31:0] m_total_var;
    logic [31:0] m_depth_scale;
    logic [31:0] first_tab [256];
    logic [31:0] second_tab [256];

    out_item_t   lik_q [$];
    dir_row_t    dir_rows [$];
    int          errors;
    int          cycles;
    int          send_idle;
    int          recv_idle;
    int          hold_req;

    copy_number_grid_likelihood dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // fixed point helpers
    function automatic longint clip(longint x);
        if (x > SAT_MAX) return SAT_MAX;
        if (x < -SAT_MAX) return -SAT_MAX;
        return x;
    endfunction

    function automatic longint unsigned absval(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned m;
        ua = absval(a);
        ub = absval(b);
        if (ub != 0 && ua > 64'h7FFF_FFFF_FFFF_FFFF / ub)
            m = SAT_MAX;
        else
            m = (ua * ub) >> 16;
        if (m > SAT_MAX)
            m = SAT_MAX;
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned m;
        ua = absval(a);
        ub = absval(b);
        if (ub == 0)
            return (a < 0) ? -SAT_MAX : SAT_MAX;
        m = (ua << 16) / ub;
        if (m > SAT_MAX)
            m = SAT_MAX;
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function automatic longint gauss_cost(longint x, longint mean, longint d);
        longint diff;
        longint q;
        diff = clip(x - mean);
        q = fx_div(fx_mul(diff, diff), d);
        return q / 2;
    endfunction

    // least grid cost for one evaluate request
    function automatic out_item_t grid_likelihood(in_item_t it);
        int        c, p, r1, r2, a, b, bestcol, mcol, sr, sc;
        int        r1lo, r1hi, r2lo, r2hi;
        int        minor0 [16];
        longint    step, np, tp, cn, dt, db, baf, best, cnv, lint, lmin, tot, ps, v, pr;
        bit        have, got;
        out_item_t res;
        c = m_cn_max;
        if (c > 15) c = 15;
        if (c < 3) c = 3;
        p = m_ps_max;
        step = it.normal_step;
        if (step >= 100) step = 99;
        np = (step * ONE_FX + 50) / 100;
        tp = ONE_FX - np;
        cn = fx_div(sx32(it.total_cn_measure), longint'(m_depth_scale));
        dt = fx_div(fx_div(fx_div(longint'(m_total_var), longint'(m_depth_scale)),
                           longint'(m_depth_scale)), longint'(it.total_cn_weight));
        baf = longint'(it.allele_fraction);
        db = fx_div(longint'(m_allele_var), longint'(it.allele_weight));
        best = 0;
        bestcol = 0;
        have = 0;
        for (int i = 0; i < 16; i++) minor0[i] = 0;
        for (r2 = 0; r2 <= c; r2++)
        begin
            for (r1 = 0; r1 <= c; r1++)
            begin
                r1lo = (r1 > p) ? r1 - p : 0;
                r1hi = (r1 > p) ? p : r1;
                r2lo = (r2 > p) ? r2 - p : 0;
                r2hi = (r2 > p) ? p : r2;
                lmin = 0;
                mcol = 0;
                got = 0;
                if ((r1 <= 1 && r2 >= 3) || (r1 >= 3 && r2 <= 1))
                    cnv = FORBID_FX;
                else
                    cnv = 2 * np + longint'(r2) * tp;
                lint = gauss_cost(cnv, cn, dt);
                // allele sub-block, column-major
                for (b = r2lo; b <= r2hi; b++)
                begin
                    for (a = r1lo; a <= r1hi; a++)
                    begin
                        sr = c - r1hi + a - r1lo;
                        sc = c - r2hi + b - r2lo;
                        if ((a == 0 && b >= 2) || (a >= 2 && b == 0))
                            ps = FORBID_FX;
                        else
                            ps = np + longint'(b) * tp;
                        pr = sx32(first_tab[(a & 15) * 16 + (b & 15)])
                           + sx32(second_tab[(sr & 15) * 16 + (sc & 15)]);
                        v = clip(gauss_cost(fx_div(ps, cn), baf, db) + clip(pr));
                        if (!got || v < lmin)
                        begin
                            lmin = v;
                            mcol = b - r2lo;
                            got = 1;
                        end
                    end
                end
                if (r1 == 0) minor0[r2 & 15] = mcol;
                tot = clip(lint + lmin);
                if (!have || tot < best)
                begin
                    best = tot;
                    bestcol = r2;
                    have = 1;
                end
            end
        end
        res.neg_log_lik = best[47:0];
        res.best_column = bestcol[3:0];
        res.best_minor = minor0[bestcol & 15][3:0];
        return res;
    endfunction

    // mismatch report
    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // model update for one accepted request
    task automatic model_request(in_item_t it);
        case (it.action)
            ACT_WR_FIRST:  first_tab[{it.row_index, it.col_index}] = it.prior_value;
            ACT_WR_SECOND: second_tab[{it.row_index, it.col_index}] = it.prior_value;
            ACT_EVAL:      lik_q.push_back(grid_likelihood(it));
            default: ;
        endcase
    endtask

    // offer one request; entered and left at a falling edge, valid left high
    task automatic send_req(in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        model_request(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (lik_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write; valid is left high for the caller to drop
    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CN_MAX:      m_cn_max = data[3:0];
            CFG_PSCN_MAX:    m_ps_max = data[3:0];
            CFG_ALLELE_VAR:  m_allele_var = data;
            CFG_TOTAL_VAR:   m_total_var = data;
            CFG_DEPTH_SCALE: m_depth_scale = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // settle the block, then write all five registers
    task automatic set_grid(logic [3:0] c, logic [3:0] p, logic [31:0] av,
                            logic [31:0] tv, logic [31:0] ds);
        wait_drained();
        repeat (300) @(negedge clk);
        write_reg(CFG_CN_MAX, {28'd0, c});
        write_reg(CFG_PSCN_MAX, {28'd0, p});
        write_reg(CFG_ALLELE_VAR, av);
        write_reg(CFG_TOTAL_VAR, tv);
        write_reg(CFG_DEPTH_SCALE, ds);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_row(logic [3:0] c, logic [3:0] p, logic [31:0] av,
                           logic [31:0] tv, logic [31:0] ds, action_t act,
                           logic [6:0] step, logic [31:0] meas, logic [31:0] tw,
                           logic [16:0] baf, logic [31:0] aw);
        dir_row_t row;
        row.cn_max = c;
        row.ps_max = p;
        row.a_var = av;
        row.t_var = tv;
        row.d_scale = ds;
        row.req = '0;
        row.req.action = act;
        row.req.normal_step = step;
        row.req.total_cn_measure = meas;
        row.req.total_cn_weight = tw;
        row.req.allele_fraction = baf;
        row.req.allele_weight = aw;
        row.req.row_index = 4'hF;
        row.req.col_index = 4'hF;
        row.req.prior_value = meas;
        dir_rows.push_back(row);
    endtask

    function automatic in_item_t rand_req();
        in_item_t it;
        int       pick;
        it.row_index = 4'($urandom_range(15));
        it.col_index = 4'($urandom_range(15));
        it.prior_value = ($urandom_range(3) == 0) ? $urandom
                                                  : $urandom_range(20 * 65536);
        it.normal_step = 7'($urandom_range(127));
        it.total_cn_measure = ($urandom_range(4) == 0) ? $urandom
                                                       : $urandom_range(6 * 65536);
        pick = $urandom_range(9);
        it.total_cn_weight = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom
                                                 : $urandom_range(1 << 14, 1 << 18);
        it.allele_fraction = 17'($urandom_range(65536));
        pick = $urandom_range(9);
        it.allele_weight = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom
                                               : $urandom_range(1 << 14, 1 << 18);
        pick = $urandom_range(99);
        if (pick < 20)
            it.action = ACT_WR_FIRST;
        else if (pick < 40)
            it.action = ACT_WR_SECOND;
        else if (pick < 95)
            it.action = ACT_EVAL;
        else
            it.action = ACT_NONE;
        return it;
    endfunction

    // cycle count and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls and long hold-offs
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                out_ready <= 1'b0;
                hold_req = hold_req - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lik_q.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = lik_q.pop_front();
                if (out_item.neg_log_lik !== want.neg_log_lik)
                    report_mismatch($sformatf("neg_log_lik %h, expected %h",
                                    out_item.neg_log_lik, want.neg_log_lik));
                if (out_item.best_column !== want.best_column)
                    report_mismatch($sformatf("best_column %0d, expected %0d",
                                    out_item.best_column, want.best_column));
                if (out_item.best_minor !== want.best_minor)
                    report_mismatch($sformatf("best_minor %0d, expected %0d",
                                    out_item.best_minor, want.best_minor));
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        in_item_t it;
        dir_row_t row;
        errors = 0;
        cycles = 0;
        hold_req = 0;
        send_idle = 22;
        recv_idle = 51;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CN_MAX;
        cfg_data = '0;
        m_cn_max = 4'd7;
        m_ps_max = 4'd3;
        m_allele_var = 32'd65536;
        m_total_var = 32'd65536;
        m_depth_scale = 32'd65536;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill every prior entry that the grids below can read
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    if (t == 1 || (r < 4 && k < 4))
                    begin
                        it = rand_req();
                        it.action = (t == 0) ? ACT_WR_FIRST : ACT_WR_SECOND;
                        it.row_index = r[3:0];
                        it.col_index = k[3:0];
                        send_req(it);
                    end
                end
            end
        end
        it = rand_req();
        it.action = ACT_WR_SECOND;
        it.row_index = 4'hF;
        it.col_index = 4'hF;
        send_req(it);

        // directed: reset settings, step extremes, grid extremes, div by zero
        add_row(7, 3, 65536, 65536, 65536, ACT_EVAL, 0, 2 * 65536, 65536, 32768, 65536);
        add_row(7, 3, 65536, 65536, 65536, ACT_EVAL, 99, 3 * 65536, 65536, 65536, 65536);
        add_row(7, 3, 65536, 65536, 65536, ACT_EVAL, 127, 65536, 65536, 0, 65536);
        add_row(15, 0, 65536, 65536, 65536, ACT_EVAL, 50, 2 * 65536, 65536, 32768, 65536);
        add_row(3, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ACT_EVAL, 30,
                32'h7FFF_FFFF, 32'hFFFF_FFFF, 65536, 32'hFFFF_FFFF);
        add_row(0, 15, 0, 0, 65536, ACT_EVAL, 10, 32'h8000_0000, 0, 1, 0);
        add_row(3, 3, 65536, 65536, 0, ACT_EVAL, 20, 65536, 65536, 32768, 65536);
        add_row(3, 3, 65536, 65536, 0, ACT_EVAL, 20, 32'hFFFF_0000, 65536, 32768, 65536);
        add_row(3, 3, 65536, 65536, 65536, ACT_NONE, 40, 65536, 65536, 32768, 65536);
        add_row(3, 3, 65536, 65536, 65536, ACT_WR_FIRST, 0, 32'h7FFF_FFFF, 0, 0, 0);
        add_row(3, 3, 65536, 65536, 65536, ACT_WR_SECOND, 0, 32'h8000_0000, 0, 0, 0);
        add_row(3, 3, 65536, 65536, 65536, ACT_EVAL, 60, 2 * 65536, 32'hFFFF_FFFF,
                65536, 32'hFFFF_FFFF);
        add_row(3, 3, 65536, 65536, 65536, ACT_EVAL, 1, 0, 65536, 0, 1);
        add_row(3, 3, 65536, 65536, 65536, ACT_EVAL, 100, 65536, 1, 65535, 65536);
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.cn_max != m_cn_max || row.ps_max != m_ps_max
                || row.a_var != m_allele_var || row.t_var != m_total_var
                || row.d_scale != m_depth_scale)
                set_grid(row.cn_max, row.ps_max, row.a_var, row.t_var, row.d_scale);
            send_req(row.req);
        end

        // random, sender idles less than receiver; one long receiver hold-off
        set_grid(3, 1, $urandom_range(1 << 12, 1 << 17), $urandom_range(1 << 12, 1 << 18),
                 65536);
        for (int n = 0; n < 70; n++)
        begin
            if (n == 10)
                hold_req = 15000;
            send_req(rand_req());
        end

        // random, receiver idles less; sender pauses for a full drain once
        set_grid(0, 0, $urandom, $urandom_range(1 << 18), 2 * 65536);
        send_idle = 51;
        recv_idle = 22;
        for (int n = 0; n < 70; n++)
        begin
            if (n == 35)
                wait_drained();
            send_req(rand_req());
        end

        // random, no idling on either side
        set_grid(3, 2, $urandom_range(1 << 17), $urandom_range(1 << 17),
                 $urandom_range(1 << 15, 1 << 17));
        send_idle = 0;
        recv_idle = 0;
        for (int n = 0; n < 70; n++)
            send_req(rand_req());

        wait_drained();
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
